[sv/motion_command_priority_arbiter_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the motion command arbiter
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MOTION_COMMAND_PRIORITY_ARBITER_CORE_MACROS_SVH
`define MOTION_COMMAND_PRIORITY_ARBITER_CORE_MACROS_SVH

// same-cycle implication
`define MCPA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCPA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mcpa_pkg.sv]
// ---------------------------------------------------------------------------
// Motion command arbiter package
// Codes, transaction types and helper functions shared by the arbiter.
// ---------------------------------------------------------------------------
package mcpa_pkg;

	localparam int CodeW  = 3;
	localparam int SpeedW = 16;
	localparam int MagW   = 15;
	localparam int TmoW   = 31;
	localparam int TimeW  = 32;
	localparam int PrioW  = 7;

	localparam logic [CodeW-1:0] ACT_TICK     = 3'd0;
	localparam logic [CodeW-1:0] ACT_SUBMIT   = 3'd1;
	localparam logic [CodeW-1:0] ACT_TANK     = 3'd2;
	localparam logic [CodeW-1:0] ACT_CLR_NORM = 3'd3;
	localparam logic [CodeW-1:0] ACT_CLR_EMER = 3'd4;

	localparam logic [CodeW-1:0] OWN_NONE      = 3'd0;
	localparam logic [CodeW-1:0] OWN_TRACKING  = 3'd1;
	localparam logic [CodeW-1:0] OWN_AUTO      = 3'd2;
	localparam logic [CodeW-1:0] OWN_MANUAL    = 3'd3;
	localparam logic [CodeW-1:0] OWN_TRANSPORT = 3'd4;
	localparam logic [CodeW-1:0] OWN_EMERGENCY = 3'd5;

	localparam logic [CodeW-1:0] MODE_STOP  = 3'd0;
	localparam logic [CodeW-1:0] MODE_RIGHT = 3'd4;
	localparam logic [CodeW-1:0] MODE_TANK  = 3'd5;

	localparam logic [PrioW-1:0] PRIO_EMERGENCY = 7'd100;
	localparam logic [PrioW-1:0] PRIO_TRANSPORT = 7'd80;
	localparam logic [PrioW-1:0] PRIO_MANUAL    = 7'd60;
	localparam logic [PrioW-1:0] PRIO_AUTO      = 7'd40;
	localparam logic [PrioW-1:0] PRIO_TRACKING  = 7'd20;
	localparam logic [PrioW-1:0] PRIO_NONE      = 7'd0;

	typedef struct packed {
		logic [CodeW-1:0]         action;
		logic [CodeW-1:0]         owner;
		logic [CodeW-1:0]         command;
		logic signed [SpeedW-1:0] speed;
		logic signed [SpeedW-1:0] tank_left;
		logic signed [SpeedW-1:0] tank_right;
		logic [TmoW-1:0]          lease_ms;
	} item_t;

	typedef struct packed {
		logic                     accepted;
		logic                     drive_update;
		logic [CodeW-1:0]         drive_mode;
		logic [MagW-1:0]          drive_magnitude;
		logic signed [SpeedW-1:0] left_drive;
		logic signed [SpeedW-1:0] right_drive;
		logic [MagW-1:0]          car_speed;
		logic                     emergency_locked;
		logic [CodeW-1:0]         current_owner;
	} result_t;

	typedef struct packed {
		logic [CodeW-1:0] holder;
		logic [TimeW-1:0] expiry_time;
		logic             lease_active;
		logic             lease_timed;
		logic [TimeW-1:0] millis_now;
		logic [MagW-1:0]  applied_speed;
	} arb_state_t;

	function automatic logic [PrioW-1:0] prio_of(input logic [CodeW-1:0] o);
		logic [PrioW-1:0] p;
		case (o)
			OWN_EMERGENCY: p = PRIO_EMERGENCY;
			OWN_TRANSPORT: p = PRIO_TRANSPORT;
			OWN_MANUAL:    p = PRIO_MANUAL;
			OWN_AUTO:      p = PRIO_AUTO;
			OWN_TRACKING:  p = PRIO_TRACKING;
			default:       p = PRIO_NONE;
		endcase
		return p;
	endfunction

	// saturating magnitude of a 16-bit signed value
	function automatic logic [MagW-1:0] mag16(input logic signed [SpeedW-1:0] s);
		logic [SpeedW-1:0] n;
		n = s[SpeedW-1] ? SpeedW'(~s + 1'b1) : s;
		return n[SpeedW-1] ? {MagW{1'b1}} : n[MagW-1:0];
	endfunction

endpackage

[sv/mcpa_decide.sv]
// ---------------------------------------------------------------------------
// Motion command arbiter decision logic
// Computes the result and the next arbiter state for one transaction.
// ---------------------------------------------------------------------------
module mcpa_decide (
	input  mcpa_pkg::item_t      item,
	input  mcpa_pkg::arb_state_t st,
	output mcpa_pkg::arb_state_t st_nxt,
	output mcpa_pkg::result_t    res
);
	import mcpa_pkg::*;

	logic [CodeW-1:0]  cmd;
	logic [TimeW-1:0]  now_inc;
	logic [TimeW-1:0]  age;
	logic              expired;
	logic              tank_stop;
	logic              owner_ok;
	logic              can_acc;
	logic              is_em;
	logic [MagW-1:0]   mag_spd;
	logic [MagW-1:0]   mag_l;
	logic [MagW-1:0]   mag_r;
	logic [MagW:0]     mag_sum;
	logic [MagW-1:0]   avg;
	logic [TimeW-1:0]  expiry_new;

	always_comb begin
		cmd        = (item.command > MODE_RIGHT) ? MODE_STOP : item.command;
		now_inc    = st.millis_now + TimeW'(1);
		age        = now_inc - st.expiry_time;
		expired    = st.lease_active && st.lease_timed && !age[TimeW-1];
		tank_stop  = (item.tank_left == '0) && (item.tank_right == '0);
		owner_ok   = (item.owner != OWN_NONE) && (item.owner <= OWN_EMERGENCY);
		can_acc    = owner_ok && (!st.lease_active || (st.holder == item.owner) ||
			(prio_of(item.owner) > prio_of(st.holder)));
		is_em      = (st.holder == OWN_EMERGENCY);
		mag_spd    = mag16(item.speed);
		mag_l      = mag16(item.tank_left);
		mag_r      = mag16(item.tank_right);
		mag_sum    = {1'b0, mag_l} + {1'b0, mag_r};
		avg        = mag_sum[MagW:1];
		expiry_new = (item.lease_ms != '0) ?
			(st.millis_now + TimeW'(item.lease_ms)) : '0;
	end

	always_comb begin
		st_nxt = st;
		res    = '0;
		case (item.action)
			ACT_TICK: begin
				st_nxt.millis_now = now_inc;
				if (expired) begin
					res.drive_update     = 1'b1;
					st_nxt.applied_speed = '0;
					st_nxt.expiry_time   = '0;
					st_nxt.lease_timed   = 1'b0;
					if (is_em) begin
						st_nxt.lease_active = 1'b1;
					end else begin
						st_nxt.holder       = OWN_NONE;
						st_nxt.lease_active = 1'b0;
					end
				end
			end
			ACT_SUBMIT, ACT_TANK: begin
				if (can_acc) begin
					res.accepted     = 1'b1;
					res.drive_update = 1'b1;
					if (item.action == ACT_TANK && !tank_stop) begin
						st_nxt.holder        = item.owner;
						st_nxt.lease_active  = 1'b1;
						st_nxt.lease_timed   = (item.lease_ms != '0);
						st_nxt.expiry_time   = expiry_new;
						st_nxt.applied_speed = avg;
						res.drive_mode       = MODE_TANK;
						res.left_drive       = item.tank_left;
						res.right_drive      = item.tank_right;
					end else if (item.action == ACT_SUBMIT && cmd != MODE_STOP) begin
						st_nxt.holder        = item.owner;
						st_nxt.lease_active  = 1'b1;
						st_nxt.lease_timed   = (item.lease_ms != '0);
						st_nxt.expiry_time   = expiry_new;
						st_nxt.applied_speed = mag_spd;
						res.drive_mode       = cmd;
						res.drive_magnitude  = mag_spd;
					end else begin
						st_nxt.applied_speed = '0;
						st_nxt.expiry_time   = '0;
						st_nxt.lease_timed   = 1'b0;
						if (item.owner == OWN_EMERGENCY) begin
							st_nxt.holder       = OWN_EMERGENCY;
							st_nxt.lease_active = 1'b1;
						end else begin
							st_nxt.holder       = OWN_NONE;
							st_nxt.lease_active = 1'b0;
						end
					end
				end
			end
			ACT_CLR_NORM, ACT_CLR_EMER: begin
				if (st.lease_active && ((item.action == ACT_CLR_NORM) ? !is_em : is_em)) begin
					res.drive_update     = 1'b1;
					st_nxt.applied_speed = '0;
					st_nxt.holder        = OWN_NONE;
					st_nxt.expiry_time   = '0;
					st_nxt.lease_active  = 1'b0;
					st_nxt.lease_timed   = 1'b0;
				end
			end
			default: begin
				st_nxt = st;
			end
		endcase
		res.car_speed        = st_nxt.applied_speed;
		res.emergency_locked = st_nxt.lease_active && (st_nxt.holder == OWN_EMERGENCY);
		res.current_owner    = st_nxt.holder;
	end

endmodule

[sv/motion_command_priority_arbiter_core.sv]
// ---------------------------------------------------------------------------
// Motion command priority arbiter
// Grants drive control to prioritized owners and issues motor commands.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries one transaction per tick,
//   submit, tank submit or clear. Response channel (rsp_valid/rsp_ready)
//   returns exactly one result per request, in order.
//   Path: each request passes through an input register and a result register
//   before its response is valid.
//   Throughput: one transaction per cycle unless rsp_ready stalls; the arbiter
//   state updates in the same cycle the input register hands its transaction
//   to the result register, so back-to-back requests see each other's effects.
//   Reset: arst_n clears both pipeline valids, the owner, the lease, the
//   millisecond counter and the applied speed.
//   Stall: while rsp_ready is low and a result waits, the input register
//   holds its transaction and req_ready drops once it is also full.
// ---------------------------------------------------------------------------
`include "motion_command_priority_arbiter_core_macros.svh"

module motion_command_priority_arbiter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic [mcpa_pkg::CodeW-1:0]            action,
	input  logic [mcpa_pkg::CodeW-1:0]            owner,
	input  logic [mcpa_pkg::CodeW-1:0]            command,
	input  logic signed [mcpa_pkg::SpeedW-1:0]    speed,
	input  logic signed [mcpa_pkg::SpeedW-1:0]    tank_left,
	input  logic signed [mcpa_pkg::SpeedW-1:0]    tank_right,
	input  logic [mcpa_pkg::TmoW-1:0]             lease_ms,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output logic                                  accepted,
	output logic                                  drive_update,
	output logic [mcpa_pkg::CodeW-1:0]            drive_mode,
	output logic [mcpa_pkg::MagW-1:0]             drive_magnitude,
	output logic signed [mcpa_pkg::SpeedW-1:0]    left_drive,
	output logic signed [mcpa_pkg::SpeedW-1:0]    right_drive,
	output logic [mcpa_pkg::MagW-1:0]             car_speed,
	output logic                                  emergency_locked,
	output logic [mcpa_pkg::CodeW-1:0]            current_owner
);
	import mcpa_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	arb_state_t st_q;
	arb_state_t st_nxt;
	result_t    res_nxt;
	logic       adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= '{action: action, owner: owner, command: command, speed: speed,
				tank_left: tank_left, tank_right: tank_right,
				lease_ms: lease_ms};
		end
	end

	mcpa_decide u_decide (
		.item   (item_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				st_q <= st_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp_valid        = valid_s2;
	assign accepted         = res_s2.accepted;
	assign drive_update     = res_s2.drive_update;
	assign drive_mode       = res_s2.drive_mode;
	assign drive_magnitude  = res_s2.drive_magnitude;
	assign left_drive       = res_s2.left_drive;
	assign right_drive      = res_s2.right_drive;
	assign car_speed        = res_s2.car_speed;
	assign emergency_locked = res_s2.emergency_locked;
	assign current_owner    = res_s2.current_owner;

	`MCPA_ASSERT_IMP(a_lock_owner, rsp_valid && emergency_locked, current_owner == OWN_EMERGENCY, "emergency lock without emergency owner")
	`MCPA_ASSERT_IMP(a_idle_drive, rsp_valid && !drive_update, drive_mode == MODE_STOP && drive_magnitude == '0 && left_drive == '0 && right_drive == '0, "drive fields set without update")
	`MCPA_ASSERT_IMP(a_acc_update, rsp_valid && accepted, drive_update, "accepted request without drive update")
	`MCPA_ASSERT_IMP(a_no_lease, !st_q.lease_active, st_q.holder == OWN_NONE && !st_q.lease_timed, "owner held without lease")
	`MCPA_ASSERT_NXT(a_tick_count, adv_s1 && item_s1.action == ACT_TICK, st_q.millis_now == TimeW'($past(st_q.millis_now) + TimeW'(1)), "tick did not advance counter")

endmodule
